[sv/zra_pkg.sv]
// shared types, operation codes and fsm states for the z[omega] ring alu
package zra_pkg;

  localparam int FIELD_W        = 64;
  localparam int OP_W           = 3;
  localparam int EXP_FIELD_W    = 16;
  localparam int COEF_WIDTH_DEF = 64;
  localparam int EXP_WIDTH_DEF  = 16;

  localparam logic [OP_W-1:0] OP_ADD   = 3'd0;
  localparam logic [OP_W-1:0] OP_SUB   = 3'd1;
  localparam logic [OP_W-1:0] OP_NEG   = 3'd2;
  localparam logic [OP_W-1:0] OP_MUL   = 3'd3;
  localparam logic [OP_W-1:0] OP_POW   = 3'd4;
  localparam logic [OP_W-1:0] OP_CONJ2 = 3'd5;
  localparam logic [OP_W-1:0] OP_CONJC = 3'd6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LIN,
    ST_MUL_GO,
    ST_MUL_WAIT,
    ST_POW_CHK,
    ST_POW_AWAIT,
    ST_POW_SWAIT
  } state_t;

  typedef struct packed {
    logic [OP_W-1:0]        op;
    logic signed [FIELD_W-1:0] x_a;
    logic signed [FIELD_W-1:0] x_b;
    logic signed [FIELD_W-1:0] x_c;
    logic signed [FIELD_W-1:0] x_d;
    logic signed [FIELD_W-1:0] y_a;
    logic signed [FIELD_W-1:0] y_b;
    logic signed [FIELD_W-1:0] y_c;
    logic signed [FIELD_W-1:0] y_d;
    logic [EXP_FIELD_W-1:0] exponent;
  } in_req_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] r_a;
    logic signed [FIELD_W-1:0] r_b;
    logic signed [FIELD_W-1:0] r_c;
    logic signed [FIELD_W-1:0] r_d;
  } out_res_t;

endpackage

[sv/zra_lin.sv]
// combinational linear ring operations: add, subtract, negate and both conjugates
module zra_lin #(
  parameter int COEF_WIDTH = zra_pkg::COEF_WIDTH_DEF
) (
  input  logic [zra_pkg::OP_W-1:0]       op,
  input  logic [3:0][COEF_WIDTH-1:0]     x,
  input  logic [3:0][COEF_WIDTH-1:0]     y,
  output logic [3:0][COEF_WIDTH-1:0]     r
);
  import zra_pkg::*;

  // element index 3..0 holds the omega^3, omega^2, omega and constant coefficients
  always_comb begin
    case (op)
      OP_ADD: begin
        for (int k = 0; k < 4; k++) r[k] = x[k] + y[k];
      end
      OP_SUB: begin
        for (int k = 0; k < 4; k++) r[k] = x[k] - y[k];
      end
      OP_NEG: begin
        for (int k = 0; k < 4; k++) r[k] = '0 - x[k];
      end
      OP_CONJ2: begin
        r[3] = '0 - x[3];
        r[2] = x[2];
        r[1] = '0 - x[1];
        r[0] = x[0];
      end
      OP_CONJC: begin
        r[3] = '0 - x[1];
        r[2] = '0 - x[2];
        r[1] = '0 - x[3];
        r[0] = x[0];
      end
      default: begin
        r = x;
      end
    endcase
  end

endmodule

[sv/zra_elem_mul.sv]
// ring element product on one shared half-width multiplier, one partial product per cycle
module zra_elem_mul #(
  parameter int COEF_WIDTH = zra_pkg::COEF_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       go,
  input  logic [3:0][COEF_WIDTH-1:0] opa,
  input  logic [3:0][COEF_WIDTH-1:0] opb,
  output logic                       done,
  output logic [3:0][COEF_WIDTH-1:0] prod
);
  import zra_pkg::*;

  localparam int H = (COEF_WIDTH + 1) / 2;
  localparam int W = COEF_WIDTH;

  localparam logic [1:0] PART_LL = 2'd0;
  localparam logic [1:0] PART_LH = 2'd1;
  localparam logic [1:0] PART_HL = 2'd2;

  logic [3:0][W-1:0] a_r, b_r, acc_r;
  logic [1:0]        i_r, i_nxt, j_r, j_nxt, part_r, part_nxt;
  logic              running_r, running_nxt;
  logic              pv_r, last_r, done_r;
  logic [2*H-1:0]    p_r;
  logic [1:0]        dest_r;
  logic              neg_r, sh_r;

  logic [W-1:0]   a_sel, b_sel;
  logic [H-1:0]   ma, mb;
  logic [2*H-1:0] p_nxt;
  logic [2:0]     pow_sum;
  logic           last_issue;
  logic [W-1:0]   term, term_s;

  assign a_sel   = a_r[i_r];
  assign b_sel   = b_r[j_r];
  assign pow_sum = {1'b0, i_r} + {1'b0, j_r};

  // low W bits of a*b = lo*lo + ((lo*hi + hi*lo) << H)
  always_comb begin
    case (part_r)
      PART_LL: begin
        ma = a_sel[H-1:0];
        mb = b_sel[H-1:0];
      end
      PART_LH: begin
        ma = a_sel[H-1:0];
        mb = H'(b_sel[W-1:H]);
      end
      PART_HL: begin
        ma = H'(a_sel[W-1:H]);
        mb = b_sel[H-1:0];
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign p_nxt = {{H{1'b0}}, ma} * {{H{1'b0}}, mb};

  assign last_issue = running_r && (i_r == 2'd3) && (j_r == 2'd3) && (part_r == PART_HL);

  always_comb begin
    running_nxt = running_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    part_nxt    = part_r;
    if (go) begin
      running_nxt = 1'b1;
      i_nxt       = '0;
      j_nxt       = '0;
      part_nxt    = PART_LL;
    end else if (running_r) begin
      if (part_r == PART_HL) begin
        part_nxt = PART_LL;
        j_nxt    = j_r + 2'd1;
        if (j_r == 2'd3) begin
          i_nxt = i_r + 2'd1;
        end
      end else begin
        part_nxt = part_r + 2'd1;
      end
      if (last_issue) begin
        running_nxt = 1'b0;
      end
    end
  end

  // omega^4 = -1: a power sum of four or more folds back with a minus sign
  assign term   = sh_r ? {p_r[W-H-1:0], {H{1'b0}}} : p_r[W-1:0];
  assign term_s = neg_r ? ('0 - term) : term;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      pv_r      <= 1'b0;
      last_r    <= 1'b0;
      done_r    <= 1'b0;
    end else begin
      running_r <= running_nxt;
      pv_r      <= running_r;
      last_r    <= last_issue;
      done_r    <= pv_r && last_r;
    end
  end

  always_ff @(posedge clk) begin
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    part_r <= part_nxt;
    p_r    <= p_nxt;
    dest_r <= pow_sum[1:0];
    neg_r  <= pow_sum[2];
    sh_r   <= (part_r != PART_LL);
    if (go) begin
      a_r   <= opa;
      b_r   <= opb;
      acc_r <= '0;
    end else if (pv_r) begin
      acc_r[dest_r] <= acc_r[dest_r] + term_s;
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

[sv/zomega_ring_alu.sv]
// top level of the z[omega] ring alu: request decode, power sequencer and result register
//
// Arithmetic on elements a*w^3 + b*w^2 + c*w + d of Z[w], w an eighth root of unity.
// A request is taken at a rising edge where start is high and busy is low; in_req
// carries the operation, both operands and the exponent. busy stays high until the
// result has been computed; the result appears on out_res for exactly one cycle,
// marked by out_valid, and the receiver cannot stall it.
// Steps from the accepting edge to the out_valid cycle:
//   add, subtract, negate, conjugates: operands registered, then the result
//   multiply: one ring product; each ring product runs 48 partial products of
//     half the coefficient width through one shared multiplier, one per cycle
//   power: a decision state before each ring product and after the last;
//     up to 2*EXP_WIDTH-1 products, fewer when the exponent has fewer set or
//     high bits, and none for a zero exponent
// One request is in flight at a time; busy drops in the out_valid cycle, so the
// next request can be taken at the edge that ends it. All coefficients wrap to
// COEF_WIDTH bits and come out sign-extended. Reset returns the sequencer to idle
// and drops out_valid; any request in progress is lost.
module zomega_ring_alu #(
  parameter int COEF_WIDTH = zra_pkg::COEF_WIDTH_DEF,
  parameter int EXP_WIDTH  = zra_pkg::EXP_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  zra_pkg::in_req_t  in_req,
  output logic              out_valid,
  output zra_pkg::out_res_t out_res
);
  import zra_pkg::*;

  state_t                       state_r, state_nxt;
  logic [OP_W-1:0]              op_r, op_nxt;
  logic [EXP_WIDTH-1:0]         exp_r, exp_nxt;
  logic [3:0][COEF_WIDTH-1:0]   x_r, x_nxt, y_r, y_nxt, acc_r, acc_nxt, sq_r, sq_nxt;
  logic [3:0][COEF_WIDTH-1:0]   in_x, in_y, lin_res, mul_opa, mul_opb, mul_prod;
  logic                         mul_go, mul_done;
  logic                         out_valid_r, out_valid_nxt;
  out_res_t                     out_res_r, out_res_nxt;

  function automatic out_res_t to_res(input logic [3:0][COEF_WIDTH-1:0] e);
    out_res_t r;
    r.r_a = FIELD_W'($signed(e[3]));
    r.r_b = FIELD_W'($signed(e[2]));
    r.r_c = FIELD_W'($signed(e[1]));
    r.r_d = FIELD_W'($signed(e[0]));
    return r;
  endfunction

  assign in_x = {in_req.x_a[COEF_WIDTH-1:0], in_req.x_b[COEF_WIDTH-1:0],
                 in_req.x_c[COEF_WIDTH-1:0], in_req.x_d[COEF_WIDTH-1:0]};
  assign in_y = {in_req.y_a[COEF_WIDTH-1:0], in_req.y_b[COEF_WIDTH-1:0],
                 in_req.y_c[COEF_WIDTH-1:0], in_req.y_d[COEF_WIDTH-1:0]};

  zra_lin #(
    .COEF_WIDTH(COEF_WIDTH)
  ) u_lin (
    .op (op_r),
    .x  (x_r),
    .y  (y_r),
    .r  (lin_res)
  );

  zra_elem_mul #(
    .COEF_WIDTH(COEF_WIDTH)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (mul_go),
    .opa   (mul_opa),
    .opb   (mul_opb),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    exp_nxt       = exp_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    acc_nxt       = acc_r;
    sq_nxt        = sq_r;
    mul_go        = 1'b0;
    mul_opa       = sq_r;
    mul_opb       = sq_r;
    out_valid_nxt = 1'b0;
    out_res_nxt   = out_res_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          op_nxt  = in_req.op;
          exp_nxt = in_req.exponent[EXP_WIDTH-1:0];
          x_nxt   = in_x;
          y_nxt   = in_y;
          case (in_req.op)
            OP_MUL: begin
              state_nxt = ST_MUL_GO;
            end
            OP_POW: begin
              acc_nxt    = '0;
              acc_nxt[0] = COEF_WIDTH'(1);
              sq_nxt     = in_x;
              state_nxt  = ST_POW_CHK;
            end
            default: begin
              state_nxt = ST_LIN;
            end
          endcase
        end
      end
      ST_LIN: begin
        out_res_nxt   = to_res(lin_res);
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_MUL_GO: begin
        mul_go    = 1'b1;
        mul_opa   = x_r;
        mul_opb   = y_r;
        state_nxt = ST_MUL_WAIT;
      end
      ST_MUL_WAIT: begin
        if (mul_done) begin
          out_res_nxt   = to_res(mul_prod);
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      // square-and-multiply from the low exponent bit, stopping once no set bits remain
      ST_POW_CHK: begin
        if (exp_r == '0) begin
          out_res_nxt   = to_res(acc_r);
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else if (exp_r[0]) begin
          mul_go    = 1'b1;
          mul_opa   = acc_r;
          mul_opb   = sq_r;
          state_nxt = ST_POW_AWAIT;
        end else begin
          mul_go    = 1'b1;
          state_nxt = ST_POW_SWAIT;
        end
      end
      ST_POW_AWAIT: begin
        if (mul_done) begin
          acc_nxt    = mul_prod;
          exp_nxt[0] = 1'b0;
          state_nxt  = ST_POW_CHK;
        end
      end
      ST_POW_SWAIT: begin
        if (mul_done) begin
          sq_nxt    = mul_prod;
          exp_nxt   = exp_r >> 1;
          state_nxt = ST_POW_CHK;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    exp_r     <= exp_nxt;
    x_r       <= x_nxt;
    y_r       <= y_nxt;
    acc_r     <= acc_nxt;
    sq_r      <= sq_nxt;
    out_res_r <= out_res_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // every result strobe is followed by a quiet cycle
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // a linear request passes through ST_LIN and then raises out_valid
  a_lin_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_req.op == OP_ADD || in_req.op == OP_SUB ||
     in_req.op == OP_NEG || in_req.op == OP_CONJ2 || in_req.op == OP_CONJC))
    |-> ##2 out_valid)
    else $error("linear request did not complete in two cycles");

  // the product unit only finishes while the sequencer waits for it
  a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (state_r == ST_MUL_WAIT || state_r == ST_POW_AWAIT ||
                  state_r == ST_POW_SWAIT))
    else $error("product finished with no request waiting for it");

  // a request only leaves idle when one was accepted
  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy && !start) |=> !busy)
    else $error("busy raised without an accepted request");

endmodule
